// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mck_pkg.sv =====
// Types, code tables and constants of the morse keyer.
`timescale 1ns / 1ps
package mck_pkg;

  localparam int LETTER_COUNT = 26;
  localparam int ROW_COUNT    = LETTER_COUNT + 10;
  localparam int ROW_W        = $clog2(ROW_COUNT);

  localparam int UNIT_W = 16;
  localparam int DUR_W  = 19;
  localparam int UNITS_W = 3;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

  localparam logic [UNITS_W-1:0] DIT_UNITS             = 3'd1;
  localparam logic [UNITS_W-1:0] DAH_UNITS             = 3'd3;
  localparam logic [UNITS_W-1:0] INTRA_CHAR_GAP_UNITS  = 3'd1;
  localparam logic [UNITS_W-1:0] INTER_CHAR_GAP_UNITS  = 3'd3;
  localparam logic [UNITS_W-1:0] WORD_GAP_UNITS        = 3'd7;
  localparam logic [UNITS_W-1:0] NO_UNITS              = 3'd0;

  // Register indexes on the configuration port.
  localparam logic REG_UNIT_TICKS = 1'b0;

  localparam int ELEM_W = 5;
  localparam int LEN_W  = 3;

  // Bit i set: element i (first sent) is a dah.
  localparam logic [ELEM_W-1:0] PATTERN_BITS [0:ROW_COUNT-1] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14,
    5'd5, 5'd2, 5'd3, 5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1,
    5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  localparam logic [LEN_W-1:0] PATTERN_LEN [0:ROW_COUNT-1] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef enum logic [1:0] {
    KIND_PATTERN,
    KIND_SPACE,
    KIND_BAD
  } kind_t;

  // One classified character, as queued between front and back.
  typedef struct packed {
    kind_t             kind;
    logic [ELEM_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } desc_t;

endpackage

// ===== rtl/mck_front.sv =====
// Front end: classifies an ASCII character into a pattern descriptor.
`timescale 1ns / 1ps
module mck_front (
  input  logic [7:0]   char_code,
  output mck_pkg::desc_t desc
);

  logic [7:0]                  offset;
  logic [mck_pkg::ROW_W-1:0]   row;
  logic                        is_pattern;

  always_comb begin
    offset     = 8'd0;
    is_pattern = 1'b1;
    desc.kind  = mck_pkg::KIND_PATTERN;
    if (char_code == 8'h20) begin
      desc.kind  = mck_pkg::KIND_SPACE;
      is_pattern = 1'b0;
    end else if (char_code inside {[8'h61:8'h7a]}) begin
      offset = char_code - 8'h61;
    end else if (char_code inside {[8'h41:8'h5a]}) begin
      offset = char_code - 8'h41;
    end else if (char_code inside {[8'h30:8'h39]}) begin
      offset = char_code - 8'h30 + 8'(mck_pkg::LETTER_COUNT);
    end else begin
      desc.kind  = mck_pkg::KIND_BAD;
      is_pattern = 1'b0;
    end
    row = offset[mck_pkg::ROW_W-1:0];
    if (is_pattern) begin
      desc.bits = mck_pkg::PATTERN_BITS[row];
      desc.len  = mck_pkg::PATTERN_LEN[row];
    end else begin
      desc.bits = '0;
      desc.len  = '0;
    end
  end

endmodule

// ===== rtl/mck_fifo.sv =====
// Short descriptor queue between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mck_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mck_pkg::desc_t wr_data,
  input  logic           rd_en,
  output mck_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mck_pkg::desc_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_underflow, clk, rst, rd_en, count != '0)
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, wr_en, count != CW'(DEPTH))

endmodule

// ===== rtl/mck_back.sv =====
// Back end: expands descriptors into key segments, one beat per cycle while its output is popped or empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mck_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mck_pkg::UNIT_W-1:0]    unit_ticks,
  input  logic                          q_empty,
  input  mck_pkg::desc_t                q_head,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic                          key_level,
  output logic [mck_pkg::DUR_W-1:0]     duration_ticks,
  output logic                          bad_char,
  output logic                          last_segment
);

  logic                              out_valid;
  logic                              busy;
  mck_pkg::desc_t                    cur;
  logic [mck_pkg::LEN_W-1:0]         idx;
  logic                              phase;

  logic                              busy_next;
  mck_pkg::desc_t                    cur_next;
  logic [mck_pkg::LEN_W-1:0]         idx_next;
  logic                              phase_next;

  mck_pkg::desc_t                    src;
  logic [mck_pkg::LEN_W-1:0]         src_idx;
  logic                              src_phase;
  logic                              advance;
  logic                              seg_level;
  logic                              seg_bad;
  logic                              seg_last;
  logic [mck_pkg::UNITS_W-1:0]       seg_units;
  logic                              final_elem;

  assign empty   = !out_valid;
  assign advance = (!out_valid || pop) && (busy || !q_empty);
  assign q_pop   = advance && !busy;

  always_comb begin
    src       = busy ? cur : q_head;
    src_idx   = busy ? idx : '0;
    src_phase = busy ? phase : 1'b0;
    final_elem = (src_idx + 1'b1 == src.len);
    seg_level = 1'b0;
    seg_bad   = 1'b0;
    seg_last  = 1'b1;
    seg_units = mck_pkg::NO_UNITS;
    case (src.kind)
      mck_pkg::KIND_SPACE: begin
        seg_units = mck_pkg::WORD_GAP_UNITS;
      end
      mck_pkg::KIND_PATTERN: begin
        if (!src_phase) begin
          seg_level = 1'b1;
          seg_last  = 1'b0;
          seg_units = src.bits[src_idx] ? mck_pkg::DAH_UNITS : mck_pkg::DIT_UNITS;
        end else begin
          seg_last  = final_elem;
          seg_units = final_elem ? mck_pkg::INTER_CHAR_GAP_UNITS
                                 : mck_pkg::INTRA_CHAR_GAP_UNITS;
        end
      end
      default: begin
        seg_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_next  = busy;
    cur_next   = cur;
    idx_next   = idx;
    phase_next = phase;
    if (advance) begin
      busy_next  = !seg_last;
      cur_next   = src;
      phase_next = !src_phase;
      idx_next   = src_phase ? src_idx + 1'b1 : src_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    idx   <= idx_next;
    phase <= phase_next;
    if (advance) begin
      key_level      <= seg_level;
      bad_char       <= seg_bad;
      last_segment   <= seg_last;
      duration_ticks <= mck_pkg::DUR_W'(seg_units) * mck_pkg::DUR_W'(unit_ticks);
    end
  end

  `ASSERT_IMPLIES(a_bad_is_lone_beat, clk, rst, out_valid && bad_char,
                  last_segment && !key_level && duration_ticks == '0)
  `ASSERT_IMPLIES(a_busy_on_pattern, clk, rst, busy, cur.kind == mck_pkg::KIND_PATTERN)
  `ASSERT_NEXT(a_mark_then_gap, clk, rst, advance && seg_level,
               busy && phase)

endmodule

// ===== rtl/morse_code_keyer.sv =====
// Top level of the morse keyer: configuration register, front, queue and back.
`timescale 1ns / 1ps
// Turns one ASCII character per beat into International Morse keying
// segments (key_level, duration_ticks). A letter or digit gives two
// segments per element (mark, then gap; the gap after the last element is
// three units and carries last_segment), a space one seven-unit gap, and
// any other code one beat with bad_char set and zero duration. The back end
// sends one segment per cycle while its output is popped or empty, and
// characters queue in a QUEUE_DEPTH-entry queue so the input keeps
// taking beats while segments drain. Durations are units times
// unit_ticks (register 0, reset 100), read when each segment is formed.
module morse_code_keyer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 char_code,
  output logic                       empty,
  input  logic                       pop,
  output logic                       key_level,
  output logic [mck_pkg::DUR_W-1:0]  duration_ticks,
  output logic                       bad_char,
  output logic                       last_segment
);

  logic [mck_pkg::UNIT_W-1:0] unit_ticks;
  logic                       reg_index;
  logic                       cfg_write;
  mck_pkg::desc_t             front_desc;
  mck_pkg::desc_t             q_head;
  logic                       q_empty;
  logic                       q_pop;
  logic                       q_push;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == mck_pkg::REG_UNIT_TICKS) ?
                     {{(32 - mck_pkg::UNIT_W){1'b0}}, unit_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= mck_pkg::UNIT_RESET;
    end else if (cfg_write && reg_index == mck_pkg::REG_UNIT_TICKS) begin
      unit_ticks <= pwdata[mck_pkg::UNIT_W-1:0];
    end
  end

  assign q_push = push && !full;

  mck_front u_front (
    .char_code (char_code),
    .desc      (front_desc)
  );

  mck_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (front_desc),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  mck_back u_back (
    .clk            (clk),
    .rst            (rst),
    .unit_ticks     (unit_ticks),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .key_level      (key_level),
    .duration_ticks (duration_ticks),
    .bad_char       (bad_char),
    .last_segment   (last_segment)
  );

endmodule

// ===== sim/mck_segment_checker.sv =====
// Checker for the morse keyer: predicts each character's segments and compares every beat.
`timescale 1ns / 1ps
module mck_segment_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic [31:0]               prdata,
  input  logic                      pready,
  input  logic                      push,
  input  logic                      full,
  input  logic [7:0]                char_code,
  input  logic                      empty,
  input  logic                      pop,
  input  logic                      key_level,
  input  logic [mck_pkg::DUR_W-1:0] duration_ticks,
  input  logic                      bad_char,
  input  logic                      last_segment,
  output int                        errors,
  output int                        pending,
  output int                        chars_taken,
  output int                        segments_seen
);

  localparam int REPORT_LIMIT = 10;
  localparam int SHORT_MARK   = 1;
  localparam int LONG_MARK    = 3;
  localparam int ELEMENT_GAP  = 1;
  localparam int LETTER_GAP   = 3;
  localparam int WORD_GAP     = 7;

  typedef struct packed {
    logic                      level;
    logic [mck_pkg::DUR_W-1:0] dur;
    logic                      bad;
    logic                      last;
  } segment_t;

  segment_t                   expected_segs[$];
  logic [mck_pkg::UNIT_W-1:0] unit_ticks;

  // Dots and dashes of a letter (upper case) or digit; empty when unknown.
  function automatic string morse_pattern(input logic [7:0] c);
    case (c)
      "A": return ".-";     "B": return "-...";   "C": return "-.-.";
      "D": return "-..";    "E": return ".";      "F": return "..-.";
      "G": return "--.";    "H": return "....";   "I": return "..";
      "J": return ".---";   "K": return "-.-";    "L": return ".-..";
      "M": return "--";     "N": return "-.";     "O": return "---";
      "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
      "S": return "...";    "T": return "-";      "U": return "..-";
      "V": return "...-";   "W": return ".--";    "X": return "-..-";
      "Y": return "-.--";   "Z": return "--..";
      "0": return "-----";  "1": return ".----";  "2": return "..---";
      "3": return "...--";  "4": return "....-";  "5": return ".....";
      "6": return "-....";  "7": return "--...";  "8": return "---..";
      "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic segment_t make_segment(input logic level, input int units,
                                            input logic bad, input logic last);
    segment_t s;
    s.level = level;
    s.dur   = mck_pkg::DUR_W'(units * int'(unit_ticks));
    s.bad   = bad;
    s.last  = last;
    return s;
  endfunction

  task automatic predict_segments(input logic [7:0] c);
    string pat;
    logic [7:0] upper;
    int i;
    upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    pat = morse_pattern(upper);
    if (c == " ") begin
      expected_segs.push_back(make_segment(1'b0, WORD_GAP, 1'b0, 1'b1));
    end else if (pat.len() == 0) begin
      expected_segs.push_back(make_segment(1'b0, 0, 1'b1, 1'b1));
    end else begin
      for (i = 0; i < pat.len(); i++) begin
        expected_segs.push_back(make_segment(1'b1,
            (pat[i] == "-") ? LONG_MARK : SHORT_MARK, 1'b0, 1'b0));
        if (i == pat.len() - 1)
          expected_segs.push_back(make_segment(1'b0, LETTER_GAP, 1'b0, 1'b1));
        else
          expected_segs.push_back(make_segment(1'b0, ELEMENT_GAP, 1'b0, 1'b0));
      end
    end
  endtask

  task automatic check_segment();
    segment_t want;
    segment_t got;
    string    exp_txt;
    got = '{key_level, duration_ticks, bad_char, last_segment};
    segments_seen++;
    if (expected_segs.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: segment with none expected: level %0b dur %0d bad %0b last %0b",
                 $realtime, got.level, got.dur, got.bad, got.last);
    end else begin
      want = expected_segs.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          exp_txt = $sformatf("level %0b dur %0d bad %0b last %0b",
                              want.level, want.dur, want.bad, want.last);
          $display("%0t: segment mismatch: exp %s, got level %0b dur %0d bad %0b last %0b",
                   $realtime, exp_txt, got.level, got.dur, got.bad, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      errors        = 0;
      pending       = 0;
      chars_taken   = 0;
      segments_seen = 0;
      unit_ticks    = mck_pkg::UNIT_RESET;
      expected_segs.delete();
    end else begin
      if (psel && penable && pready && pwrite && paddr[2:2] == mck_pkg::REG_UNIT_TICKS)
        unit_ticks = pwdata[mck_pkg::UNIT_W-1:0];
      if (psel && penable && pready && !pwrite && paddr[2:2] == mck_pkg::REG_UNIT_TICKS &&
          prdata !== 32'(unit_ticks)) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unit_ticks readback: exp %0d got %0d",
                   $realtime, unit_ticks, prdata);
      end
      if (push && !full) begin
        chars_taken++;
        predict_segments(char_code);
      end
      if (pop && !empty)
        check_segment();
      pending = expected_segs.size();
    end
  end

endmodule

// ===== sim/tb_morse_code_keyer.sv =====
// Testbench top for the morse keyer: clock, reset, stimulus, result drain and verdict.
`timescale 1ns / 1ps
module tb_morse_code_keyer;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_COUNT   = 5;
  localparam int PHASE_CHARS   = 87;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PERCENT  = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam logic [2:0] UNIT_ADDR   = {mck_pkg::REG_UNIT_TICKS, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;
  logic                      push = 1'b0;
  logic                      full;
  logic [7:0]                char_code = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic                      key_level;
  logic [mck_pkg::DUR_W-1:0] duration_ticks;
  logic                      bad_char;
  logic                      last_segment;

  int errors;
  int pending;
  int chars_taken;
  int segments_seen;
  int cycle_count = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic steady = 1'b0;

  always #10 clk = ~clk;

  morse_code_keyer u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .char_code(char_code),
    .empty(empty), .pop(pop),
    .key_level(key_level), .duration_ticks(duration_ticks),
    .bad_char(bad_char), .last_segment(last_segment)
  );

  mck_segment_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .char_code(char_code),
    .empty(empty), .pop(pop),
    .key_level(key_level), .duration_ticks(duration_ticks),
    .bad_char(bad_char), .last_segment(last_segment),
    .errors(errors), .pending(pending),
    .chars_taken(chars_taken), .segments_seen(segments_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random pop, a long hold when asked, none while steady.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      pop <= 1'b0;
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
    end else if (steady) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] c);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      char_code <= 8'($urandom);
      @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted segment has come back.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 8'("A" + $urandom_range(25));
    if (r < 60) return 8'("a" + $urandom_range(25));
    if (r < 80) return 8'("0" + $urandom_range(9));
    if (r < 88) return " ";
    return 8'($urandom_range(255));
  endfunction

  initial begin
    string directed;
    logic [15:0] phase_unit [PHASE_COUNT];
    int p;
    int i;
    directed = "Az09 @[`{/:ETQ5Y";
    phase_unit[0] = 16'hFFFF;
    phase_unit[1] = 16'd1;
    phase_unit[2] = 16'($urandom_range(65535));
    phase_unit[3] = 16'($urandom_range(2, 20));
    phase_unit[4] = mck_pkg::UNIT_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, UNIT_ADDR, '0);

    // Reset unit: edge codes, every class, shortest and longest patterns.
    for (i = 0; i < directed.len(); i++)
      send_char(directed[i]);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    drain();

    // Zero unit keeps every duration at zero.
    reg_access(1'b1, UNIT_ADDR, 32'hABCD_0000);
    send_char("K");
    send_char(" ");
    send_char("e");
    drain();

    reg_access(1'b1, UNIT_ADDR, 32'h0000_FFFF);
    send_char("0");
    send_char(" ");
    send_char("B");
    drain();

    // Write to an address with no register; unit must stay put.
    reg_access(1'b1, UNUSED_ADDR, 32'h0000_0005);
    reg_access(1'b0, UNIT_ADDR, '0);

    for (p = 0; p < PHASE_COUNT; p++) begin
      reg_access(1'b1, UNIT_ADDR, {16'($urandom), phase_unit[p]});
      reg_access(1'b0, UNIT_ADDR, '0);
      if (p == 2) steady <= 1'b1;
      for (i = 0; i < PHASE_CHARS; i++) begin
        if (p == 1 && i == 10) hold_token <= hold_token + 1;
        send_char(pick_char());
      end
      drain();
      steady <= 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d characters and %0d segments: letters of both cases, digits,",
             chars_taken, segments_seen);
    $display("space and unknown codes at unit 0, 1, 100, 65535 and random units, with stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
